[sv/sinc_squared_profile_eval_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sinc-squared profile evaluator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SINC_SQUARED_PROFILE_EVAL_UNIT_MACROS_SVH
`define SINC_SQUARED_PROFILE_EVAL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sinc profile unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sinc profile unit: next-cycle check failed");

`endif

[sv/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// Sinc-squared profile package
// Widths, constants, register indexes and cell slot types.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Fraction bits of the ratio and of the polynomial arithmetic.
    localparam int UF        = 30;
    localparam int NUM_W     = 62;
    localparam int REM_W     = 48;
    localparam int TAG_W     = 33;
    localparam int DIV1_STEPS = 62;
    localparam int DIV2_STEPS = 32;
    localparam int POLY_STEPS = 5;
    localparam int FAR_BITS  = 16;

    localparam logic [31:0] PI30   = 32'd3373259426;
    localparam logic [29:0] HALF_Q = 30'h2000_0000;
    localparam logic [30:0] ONE_Q  = 31'h4000_0000;

    localparam logic signed [31:0] POLY_C [POLY_STEPS+1] = '{
        -32'sd27, 32'sd2959, -32'sd213045, 32'sd8947849, -32'sd178956971,
        32'sd1073741824
    };

    typedef enum logic [1:0] {
        REG_BASE_OFFSET = 2'd0,
        REG_PEAK_GAIN   = 2'd1,
        REG_CENTER_POS  = 2'd2,
        REG_SLIT_WIDTH  = 2'd3
    } reg_idx_t;

    // One slot of a restoring divider chain.
    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] den;
        logic [TAG_W-1:0] tag;
    } div_slot_t;

    // One slot of the polynomial evaluation chain.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] p;
        logic [31:0]        z;
        logic [30:0]        x;
        logic [47:0]        pu;
        logic               far;
        logic               near;
    } poly_slot_t;

endpackage

[sv/ssp_div_cell.sv]
// ----------------------------------------------------------------------------
// Restoring divider cell
// Retires one quotient bit per cell and hands the slot to the next cell.
// ----------------------------------------------------------------------------
module ssp_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  ssp_pkg::div_slot_t slot_in,
    output ssp_pkg::div_slot_t slot_out
);
    import ssp_pkg::*;

    logic [REM_W:0] trial;
    logic           fits;
    div_slot_t      slot_next;
    div_slot_t      slot_reg;

    always_comb begin
        trial = {slot_in.rem, slot_in.num[NUM_W-1]};
        fits  = trial >= {1'b0, slot_in.den};
        slot_next = slot_in;
        slot_next.num = {slot_in.num[NUM_W-2:0], fits};
        if (fits) begin
            slot_next.rem = REM_W'(trial - {1'b0, slot_in.den});
        end else begin
            slot_next.rem = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (ce) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

[sv/ssp_poly_cell.sv]
// ----------------------------------------------------------------------------
// Polynomial step cell
// One Horner step: p = coef + floor(p * z / 2^30), registered.
// ----------------------------------------------------------------------------
module ssp_poly_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  logic signed [31:0] coef,
    input  ssp_pkg::poly_slot_t slot_in,
    output ssp_pkg::poly_slot_t slot_out
);
    import ssp_pkg::*;

    logic signed [64:0] prod;
    logic signed [64:0] prod_sh;
    poly_slot_t         slot_next;
    poly_slot_t         slot_reg;

    always_comb begin
        prod      = 65'(slot_in.p) * $signed({1'b0, slot_in.z});
        prod_sh   = prod >>> UF;
        slot_next = slot_in;
        slot_next.p = coef + $signed(prod_sh[31:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (ce) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

[sv/sinc_squared_profile_eval_unit.sv]
// ----------------------------------------------------------------------------
// Sinc-squared profile evaluator, top level
// value = base_offset + peak_gain * sinc^2(pi*(coord - center_pos)/slit_width)
// ----------------------------------------------------------------------------
// Usage: coordinates arrive on the s_ stream (signed Q16.16 in s_tdata), one
// transfer per item. Each item yields exactly one result transfer on the m_
// stream: the saturated Q16.16 value in m_tdata and the clip flag in m_tuser.
// The four model registers are written through cfg_wr_en/cfg_addr/cfg_wdata;
// the user must write them only while the pipeline is empty (not enforced).
// Throughput is one item per cycle while results are taken. The path from an
// input transfer to a valid result is set mostly by the two divider
// chains: 62 cells for the ratio |t - center| / width and 32 cells for the
// sine-over-argument quotient, plus five Horner cells and the multiply stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults. When the receiver stalls, the whole pipeline holds and
// s_tready drops until the output register is taken.
// ----------------------------------------------------------------------------
module sinc_squared_profile_eval_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [0:0]  m_tuser,   // [0] saturated
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import ssp_pkg::*;

    // Model registers.
    logic [31:0] base_offset_reg;
    logic [31:0] peak_gain_reg;
    logic [31:0] center_pos_reg;
    logic [30:0] slit_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_offset_reg <= '0;
            peak_gain_reg   <= 32'(1000) << FRAC_BITS;
            center_pos_reg  <= 32'(64) << FRAC_BITS;
            slit_width_reg  <= 31'(10) << FRAC_BITS;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_BASE_OFFSET: base_offset_reg <= cfg_wdata;
                REG_PEAK_GAIN:   peak_gain_reg   <= cfg_wdata;
                REG_CENTER_POS:  center_pos_reg  <= cfg_wdata;
                REG_SLIT_WIDTH:  slit_width_reg  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the output register
    // is free or is being taken in this cycle.
    logic ce;
    logic m_tvalid_reg;
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // Entry: absolute distance from the center, loaded into the first
    // divider slot. A zero width behaves as the smallest width.
    logic signed [32:0] delta;
    logic [31:0]        dist_abs;
    logic [30:0]        width_eff;
    div_slot_t          div1_in_next;
    div_slot_t          div1_in_reg;

    always_comb begin
        delta     = $signed({s_tdata[31], s_tdata}) -
                    $signed({center_pos_reg[31], center_pos_reg});
        dist_abs  = delta[32] ? 32'(~delta + 33'sd1) : delta[31:0];
        width_eff = (slit_width_reg == '0) ? 31'd1 : slit_width_reg;
        div1_in_next.valid = s_tvalid;
        div1_in_next.num   = {dist_abs, 30'd0};
        div1_in_next.rem   = '0;
        div1_in_next.den   = REM_W'(width_eff);
        div1_in_next.tag   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div1_in_reg.valid <= 1'b0;
        end else if (ce) begin
            div1_in_reg <= div1_in_next;
        end
    end

    // First divider chain: integer part and 30 fraction bits of the ratio.
    div_slot_t div1_slot [DIV1_STEPS+1];
    assign div1_slot[0] = div1_in_reg;

    for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
        ssp_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .slot_in (div1_slot[i]),
            .slot_out(div1_slot[i+1])
        );
    end

    // Fold the fraction onto the first half period and classify the item.
    logic [31:0] ratio_q;
    logic [29:0] ratio_f;
    logic        st2_valid_reg;
    logic [29:0] st2_g_reg;
    logic [15:0] st2_q_reg;
    logic [29:0] st2_f_reg;
    logic        st2_far_reg;
    logic        st2_near_reg;

    assign ratio_q = div1_slot[DIV1_STEPS].num[NUM_W-1:UF];
    assign ratio_f = div1_slot[DIV1_STEPS].num[UF-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (ce) begin
            st2_valid_reg <= div1_slot[DIV1_STEPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st2_g_reg    <= (ratio_f <= HALF_Q) ? ratio_f : 30'(ONE_Q - {1'b0, ratio_f});
            st2_q_reg    <= ratio_q[FAR_BITS-1:0];
            st2_f_reg    <= ratio_f;
            st2_far_reg  <= |ratio_q[31:FAR_BITS];
            st2_near_reg <= (ratio_q == '0) && (ratio_f <= HALF_Q);
        end
    end

    // Scale by pi: polynomial argument and the sinc denominator parts.
    logic [61:0] g_pi;
    logic [61:0] f_pi;
    logic [47:0] q_pi;
    logic        st3_valid_reg;
    logic [30:0] st3_x_reg;
    logic [47:0] st3_qpi_reg;
    logic [31:0] st3_fpi_reg;
    logic        st3_far_reg;
    logic        st3_near_reg;

    always_comb begin
        g_pi = 62'(st2_g_reg) * 62'(PI30);
        f_pi = 62'(st2_f_reg) * 62'(PI30);
        q_pi = 48'(st2_q_reg) * 48'(PI30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else if (ce) begin
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st3_x_reg    <= g_pi[60:UF];
            st3_qpi_reg  <= q_pi;
            st3_fpi_reg  <= f_pi[61:UF];
            st3_far_reg  <= st2_far_reg;
            st3_near_reg <= st2_near_reg;
        end
    end

    // Square of the argument and the full denominator pi*u.
    logic [61:0] x_sq;
    poly_slot_t  poly_in_next;
    poly_slot_t  poly_in_reg;

    always_comb begin
        x_sq = 62'(st3_x_reg) * 62'(st3_x_reg);
        poly_in_next.valid = st3_valid_reg;
        poly_in_next.p     = POLY_C[0];
        poly_in_next.z     = x_sq[61:UF];
        poly_in_next.x     = st3_x_reg;
        poly_in_next.pu    = st3_qpi_reg + 48'(st3_fpi_reg);
        poly_in_next.far   = st3_far_reg;
        poly_in_next.near  = st3_near_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_in_reg.valid <= 1'b0;
        end else if (ce) begin
            poly_in_reg <= poly_in_next;
        end
    end

    // Horner chain for the sinc polynomial in z.
    poly_slot_t poly_slot [POLY_STEPS+1];
    assign poly_slot[0] = poly_in_reg;

    for (genvar i = 0; i < POLY_STEPS; i++) begin : g_poly
        ssp_poly_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .coef    (POLY_C[i+1]),
            .slot_in (poly_slot[i]),
            .slot_out(poly_slot[i+1])
        );
    end

    // Clamp the polynomial to [0, 1].
    poly_slot_t  poly_out;
    logic        st5_valid_reg;
    logic [30:0] st5_pc_reg;
    logic [30:0] st5_x_reg;
    logic [47:0] st5_pu_reg;
    logic        st5_far_reg;
    logic        st5_near_reg;

    assign poly_out = poly_slot[POLY_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st5_valid_reg <= 1'b0;
        end else if (ce) begin
            st5_valid_reg <= poly_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (poly_out.p < 0) begin
                st5_pc_reg <= '0;
            end else if (poly_out.p > $signed({1'b0, ONE_Q})) begin
                st5_pc_reg <= ONE_Q;
            end else begin
                st5_pc_reg <= poly_out.p[30:0];
            end
            st5_x_reg    <= poly_out.x;
            st5_pu_reg   <= poly_out.pu;
            st5_far_reg  <= poly_out.far;
            st5_near_reg <= poly_out.near;
        end
    end

    // Sine magnitude and the near-center square, then the second divider.
    logic [61:0] sin_prod;
    logic [61:0] pc_sq;
    logic [30:0] sin_mag;
    div_slot_t   div2_in_next;
    div_slot_t   div2_in_reg;

    always_comb begin
        sin_prod = 62'(st5_x_reg) * 62'(st5_pc_reg);
        pc_sq    = 62'(st5_pc_reg) * 62'(st5_pc_reg);
        sin_mag  = sin_prod[60:UF];
        div2_in_next.valid = st5_valid_reg;
        div2_in_next.num   = {sin_mag[1:0], 60'd0};
        div2_in_next.rem   = REM_W'(sin_mag[30:2]);
        div2_in_next.den   = st5_pu_reg;
        div2_in_next.tag   = {st5_far_reg, st5_near_reg, pc_sq[60:UF]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div2_in_reg.valid <= 1'b0;
        end else if (ce) begin
            div2_in_reg <= div2_in_next;
        end
    end

    // Second divider chain: sin(pi*u) / (pi*u) with 30 fraction bits.
    div_slot_t div2_slot [DIV2_STEPS+1];
    assign div2_slot[0] = div2_in_reg;

    for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_div2
        ssp_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .slot_in (div2_slot[i]),
            .slot_out(div2_slot[i+1])
        );
    end

    // Squared sinc, chosen by branch.
    div_slot_t   div2_out;
    logic [31:0] ratio_rr;
    logic [63:0] rr_sq;
    logic        st7_valid_reg;
    logic [33:0] st7_s2_reg;

    always_comb begin
        div2_out = div2_slot[DIV2_STEPS];
        ratio_rr = div2_out.num[31:0];
        rr_sq    = 64'(ratio_rr) * 64'(ratio_rr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st7_valid_reg <= 1'b0;
        end else if (ce) begin
            st7_valid_reg <= div2_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (div2_out.tag[TAG_W-1]) begin
                st7_s2_reg <= '0;
            end else if (div2_out.tag[TAG_W-2]) begin
                st7_s2_reg <= 34'(div2_out.tag[TAG_W-3:0]);
            end else begin
                st7_s2_reg <= rr_sq[63:UF];
            end
        end
    end

    // Gain magnitude times s2, split into high and low partial products.
    logic [31:0] gain_mag;
    logic        st8_valid_reg;
    logic [50:0] st8_hi_reg;
    logic [46:0] st8_lo_reg;
    logic        st8_neg_reg;

    assign gain_mag = peak_gain_reg[31] ? (~peak_gain_reg + 32'd1) : peak_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st8_valid_reg <= 1'b0;
        end else if (ce) begin
            st8_valid_reg <= st7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st8_hi_reg  <= 51'(gain_mag) * 51'(st7_s2_reg[33:15]);
            st8_lo_reg  <= 47'(gain_mag) * 47'(st7_s2_reg[14:0]);
            st8_neg_reg <= peak_gain_reg[31];
        end
    end

    // Combine the partial products into the term magnitude.
    logic [51:0] part_sum;
    logic        st9_valid_reg;
    logic [36:0] st9_t_reg;
    logic        st9_neg_reg;

    assign part_sum = 52'(st8_hi_reg) + 52'(st8_lo_reg[46:15]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st9_valid_reg <= 1'b0;
        end else if (ce) begin
            st9_valid_reg <= st8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st9_t_reg   <= part_sum[51:15];
            st9_neg_reg <= st8_neg_reg;
        end
    end

    // Signed sum with the offset and saturation into the output register.
    logic signed [38:0] term;
    logic signed [39:0] total;
    logic               clip_hi;
    logic               clip_lo;
    logic [31:0]        value_next;
    logic [31:0]        m_tdata_reg;
    logic               m_tuser_reg;

    always_comb begin
        term = st9_neg_reg ? -$signed({2'b00, st9_t_reg}) : $signed({2'b00, st9_t_reg});
        total   = 40'($signed(base_offset_reg)) + 40'(term);
        clip_hi = total > 40'sd2147483647;
        clip_lo = total < -40'sd2147483648;
        if (clip_hi) begin
            value_next = 32'h7FFF_FFFF;
        end else if (clip_lo) begin
            value_next = 32'h8000_0000;
        end else begin
            value_next = total[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= st9_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= value_next;
            m_tuser_reg <= clip_hi || clip_lo;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[sv/ssp_checker.sv]
// ----------------------------------------------------------------------------
// Sinc-squared profile port checker
// Watches the top-level streams and checks handshake and result rules.
// ----------------------------------------------------------------------------
`include "sinc_squared_profile_eval_unit_macros.svh"

module ssp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);
    // A stalled result stays offered.
    `SSP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // A stalled result keeps its value and flag.
    `SSP_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // A clipped result sits on one of the two bounds.
    `SSP_ASSERT_SAME(a_clip_bound, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata == 32'h7FFF_FFFF) || (m_tdata == 32'h8000_0000))

    // The input side only backs off while a result waits on the output.
    `SSP_ASSERT_SAME(a_ready_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

endmodule

bind sinc_squared_profile_eval_unit ssp_checker u_ssp_checker (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for the sinc-squared profile evaluator
// Streams coordinates through the unit under several register settings and
// stall patterns, and checks every result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;
    import ssp_pkg::*;

    // Pipeline drain allowance and run length limit.
    localparam int LATENCY = 110;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // A predicted result: the model value and the clip flag.
    typedef struct {
        logic [31:0] value;
        logic        saturated;
    } profile_point_t;

    // Copy of the model registers held by the predictor.
    logic signed [31:0] model_offset;
    logic signed [31:0] model_gain;
    logic signed [31:0] model_center;
    logic [30:0]        model_width;

    logic [31:0]    coord_queue[$];
    profile_point_t expected_points[$];
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    bit             hold_sender = 1'b0;
    int             error_count = 0;
    longint         cycle_count = 0;

    sinc_squared_profile_eval_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Floor division by 2^30 of a signed product.
    function automatic longint floor_q30(longint v);
        return v >>> UF;
    endfunction

    // Polynomial approximation of sinc(pi*g) for g up to one half. The scaled
    // argument x = g*pi is returned as well since the sine path reuses it.
    function automatic longint sinc_series(longint unsigned g,
                                           output longint unsigned x_out);
        longint unsigned x, z;
        longint p;
        x = (g * PI30) >> UF;
        z = (x * x) >> UF;
        p = POLY_C[0];
        for (int i = 1; i <= POLY_STEPS; i++)
            p = longint'(POLY_C[i]) + floor_q30(p * longint'(z));
        if (p < 0) p = 0;
        if (p > longint'(ONE_Q)) p = ONE_Q;
        x_out = x;
        return p;
    endfunction

    // Expected result for one coordinate under the current registers.
    function automatic profile_point_t predict_profile(logic [31:0] coord);
        profile_point_t res;
        longint d, gain_l, term, sum;
        longint unsigned dist_mag, width, quot, rem, frac, sq, x, p, g;
        longint unsigned sine_mag, arg, ratio, mag, part_a, part_b, t;
        d = longint'($signed(coord)) - longint'(model_center);
        dist_mag = (d < 0) ? -d : d;
        width = (model_width == 0) ? 1 : model_width;
        quot = dist_mag / width;
        rem = dist_mag % width;
        frac = 0;
        for (int i = 0; i < UF; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= width) begin
                rem = rem - width;
                frac = frac | 1;
            end
        end
        if (quot >= (64'd1 << FAR_BITS)) begin
            sq = 0;
        end else if (quot == 0 && frac <= HALF_Q) begin
            p = sinc_series(frac, x);
            sq = (p * p) >> UF;
        end else begin
            // Fold the fraction so that the sine argument stays in [0, pi/2].
            g = (frac <= HALF_Q) ? frac : longint'(ONE_Q) - frac;
            p = sinc_series(g, x);
            sine_mag = (x * p) >> UF;
            arg = quot * PI30 + ((frac * PI30) >> UF);
            ratio = (sine_mag << UF) / arg;
            sq = (ratio * ratio) >> UF;
        end
        gain_l = model_gain;
        mag = (gain_l < 0) ? -gain_l : gain_l;
        part_a = mag * (sq >> 15);
        part_b = mag * (sq & 64'h7FFF);
        t = (part_a + (part_b >> 15)) >> 15;
        term = (gain_l < 0) ? -longint'(t) : longint'(t);
        sum = longint'(model_offset) + term;
        res.saturated = 1'b0;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            res.saturated = 1'b1;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.value = sum[31:0];
        return res;
    endfunction

    // Driver: presents queued coordinates, predicting each one on transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_points.push_back(predict_profile(s_tdata));
                void'(coord_queue.pop_front());
            end
            // Decide whether the next cycle offers an item. The head of the
            // queue is the item on the bus until it has been accepted.
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (coord_queue.size() != 0
                         && !hold_sender
                         && $urandom_range(99, 0) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= coord_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and the comparison against predictions.
    always @(posedge aclk) begin
        profile_point_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result transfer: value %h", m_tdata);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (m_tdata !== want.value) begin
                    $error("value: expected %h actual %h", want.value, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $error("saturated: expected %b actual %b", want.saturated,
                           m_tuser[0]);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Limit on run length; a stuck pipeline ends here.
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Writes one model register and mirrors it into the predictor copy.
    task automatic write_reg(reg_idx_t idx, logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BASE_OFFSET: model_offset = data;
            REG_PEAK_GAIN:   model_gain = data;
            REG_CENTER_POS:  model_center = data;
            REG_SLIT_WIDTH:  model_width = data[30:0];
            default: ;
        endcase
    endtask

    // Waits until all items went in and all results came out.
    task automatic drain;
        while (coord_queue.size() != 0 || s_tvalid || expected_points.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Random coordinate, mostly close to the center so the main lobe and the
    // first side lobes are exercised, sometimes anywhere.
    function automatic logic [31:0] random_coord();
        int span;
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return model_center + $signed(32'($urandom_range(2, 0)) - 1);
            default: begin
                span = (model_width < 31'h0100_0000) ? model_width * 8 : 32'h7FFF_FFFF;
                return model_center + $signed($urandom_range(span, 0)
                                              - span / 2);
            end
        endcase
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) coord_queue.push_back(random_coord());
        drain();
    endtask

    initial begin
        model_offset = 0;
        model_gain = 32'd1000 << FRAC_BITS;
        model_center = 32'd64 << FRAC_BITS;
        model_width = 31'd10 << FRAC_BITS;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with reset registers: exact center, one unit off, half,
        // one and one and a half widths off, far points and the coordinate extremes.
        coord_queue.push_back(model_center);
        coord_queue.push_back(model_center + 1);
        coord_queue.push_back(model_center - 1);
        coord_queue.push_back(model_center + (model_width >> 1));
        coord_queue.push_back(model_center + model_width);
        coord_queue.push_back(model_center - model_width * 3 / 2);
        coord_queue.push_back(32'h7FFF_FFFF);
        coord_queue.push_back(32'h8000_0000);
        coord_queue.push_back(32'h0000_0000);
        coord_queue.push_back(32'hFFFF_FFFF);
        coord_queue.push_back(32'h5555_5555);
        coord_queue.push_back(32'hAAAA_AAAA);
        drain();

        // Smallest width (zero is treated as one) and saturation both ways.
        write_reg(REG_SLIT_WIDTH, 32'd0);
        write_reg(REG_BASE_OFFSET, 32'h7FFF_0000);
        write_reg(REG_PEAK_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_POS, 32'h0000_0000);
        coord_queue.push_back(32'h0000_0000);
        coord_queue.push_back(32'h0000_0001);
        coord_queue.push_back(32'h8000_0000);
        drain();
        write_reg(REG_BASE_OFFSET, 32'h8000_0000);
        write_reg(REG_PEAK_GAIN, 32'h8000_0000);
        write_reg(REG_SLIT_WIDTH, 32'hFFFF_FFFF);
        write_reg(REG_CENTER_POS, 32'h8000_0000);
        coord_queue.push_back(32'h8000_0000);
        coord_queue.push_back(32'h7FFF_FFFF);
        coord_queue.push_back(32'h0000_0000);
        drain();

        // Random part: register settings change between phases, stall
        // patterns cycle through none, sender idle, receiver stall and both.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_BASE_OFFSET, (ph % 5 == 0) ? $urandom : $urandom_range(32'h0100_0000, 0) - 32'h0080_0000);
            write_reg(REG_PEAK_GAIN, (ph % 4 == 3) ? $urandom : $urandom_range(32'h1000_0000, 0) - 32'h0800_0000);
            write_reg(REG_CENTER_POS, $urandom);
            write_reg(REG_SLIT_WIDTH, (ph % 6 == 5) ? $urandom : $urandom_range(32'h0100_0000, 1));
            case (ph % 4)
                0: random_phase(100, 0, 0);
                1: random_phase(100, 78, 0);
                2: random_phase(100, 0, 78);
                default: random_phase(100, 10, 10);
            endcase
        end

        // The sender holds off until the pipeline has drained, then resumes.
        send_idle_pct = 0;
        recv_stall_pct = 30;
        repeat (20) coord_queue.push_back(random_coord());
        repeat (5) @(posedge aclk);
        hold_sender = 1'b1;
        while (expected_points.size() != 0) @(posedge aclk);
        hold_sender = 1'b0;
        drain();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/ssp_pkg.sv
sv/ssp_div_cell.sv
sv/ssp_poly_cell.sv
sv/sinc_squared_profile_eval_unit.sv
sv/ssp_checker.sv
test/testbench.sv
